// ----- src/art_pkg.sv -----
// Package for the address region tracker.
// Holds the transaction payload types, command and status codes and the default table size.
// No dependencies.
package art_pkg;

  // Default number of table slots. Slot 0 is reserved as the null link.
  localparam int unsigned ART_SLOTS_DEFAULT = 256;

  // Command codes.
  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_RELEASE  = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_OVERLAP  = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Input transaction.
  typedef struct packed {
    logic        cmd;
    logic [31:0] address;
    logic [31:0] length;
  } art_in_t;

  // Result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [7:0]  live_count;
    logic [32:0] total_bytes;
    logic [31:0] released_length;
  } art_out_t;

endpackage

// ----- src/address_region_tracker.sv -----
// Address region tracker: slot table of regions linked in ascending start order.
// Depends on art_pkg for payload types, command codes and status codes.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | art_in_t  (cmd, address, length)
//   out     | output    | out_valid / out_ready  | art_out_t (status, slot, live_count,
//           |           |                        |            total_bytes, released_length)
//
// After reset the slot-use memory is cleared one entry a cycle, while in_ready stays low.
// A register scans the slot-use memory one slot a cycle for the lowest free slot, reporting a
// full table when none is free, then reads the head, walks the list node by node and, if the
// region is placed, links it in S_LINK1 and S_LINK2. A release reads the head and walks the
// list node by node. The result state then loads the output register, where a stalled
// result holds the sequencer; in_ready is high only when idle.
module address_region_tracker #(
  parameter int unsigned TABLE_SLOTS = art_pkg::ART_SLOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  art_pkg::art_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output art_pkg::art_out_t out_data
);
  import art_pkg::*;

  localparam int unsigned SW = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);
  localparam logic [SW-1:0] NULL_SLOT = '0;
  localparam logic [SW-1:0] ONE_SLOT  = SW'(1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FREE, S_HEAD, S_WALK, S_LINK1, S_LINK2, S_RESP
  } state_t;

  // Table memories; read data is only used from entries already written.
  logic [31:0]   start_mem [TABLE_SLOTS];
  logic [32:0]   end_mem   [TABLE_SLOTS];
  logic [SW-1:0] next_mem  [TABLE_SLOTS];
  logic          used_mem  [TABLE_SLOTS];

  state_t        state_r;
  logic [SW-1:0] clr_r;
  logic [SW-1:0] head_r;
  logic [SW-1:0] count_r;
  logic [32:0]   total_r;

  // Current transaction.
  logic          cmd_r;
  logic [31:0]   addr_r;
  logic [31:0]   len_r;
  logic [32:0]   end_r;

  // Sequencer working registers.
  logic [SW-1:0] scan_r;
  logic [SW-1:0] chk_r;
  logic          chk_vld_r;
  logic [SW-1:0] b_r;
  logic [SW-1:0] cur_r;
  logic [SW-1:0] prev_slot_r;
  logic [32:0]   prev_end_r;
  logic [SW-1:0] lo_r;
  logic [SW-1:0] hi_r;
  logic [1:0]    stat_r;
  logic [SW-1:0] slot_res_r;
  logic [31:0]   rel_r;

  logic          out_valid_r;
  art_out_t      out_data_r;

  // Registered read data.
  logic [31:0]   start_q;
  logic [32:0]   end_q;
  logic [SW-1:0] next_q;
  logic          used_q;

  // Memory port controls.
  logic [SW-1:0] rd_addr;
  logic          se_we;
  logic          nxt_we;
  logic [SW-1:0] nxt_wa;
  logic [SW-1:0] nxt_wd;
  logic          used_we;
  logic [SW-1:0] used_wa;
  logic          used_wd;

  // Shared compare unit on the node just read.
  logic [32:0] addr_ext;
  logic [32:0] start_ext;
  logic        eq_start;
  logic        below;
  logic        prev_clash;
  logic        succ_clash;
  logic        tail_clash;
  logic        at_tail;
  logic        hit;
  logic [31:0] node_len;

  assign addr_ext   = {1'b0, addr_r};
  assign start_ext  = {1'b0, start_q};
  assign eq_start   = (addr_r == start_q);
  assign below      = (addr_r < start_q);
  assign prev_clash = (prev_slot_r != NULL_SLOT) && (addr_ext < prev_end_r);
  assign succ_clash = (end_r > start_ext);
  assign tail_clash = (addr_ext < end_q);
  assign at_tail    = (next_q == NULL_SLOT);
  assign hit        = !below && (addr_ext < end_q);
  assign node_len   = 32'(end_q - start_ext);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Read address and write port selection.
  always_comb begin
    rd_addr = cur_r;
    se_we   = 1'b0;
    nxt_we  = 1'b0;
    nxt_wa  = b_r;
    nxt_wd  = hi_r;
    used_we = 1'b0;
    used_wa = clr_r;
    used_wd = 1'b0;
    case (state_r)
      S_CLEAR: begin
        used_we = 1'b1;
      end
      S_HEAD: begin
        rd_addr = head_r;
      end
      S_WALK: begin
        rd_addr = next_q;
        if (cmd_r == CMD_RELEASE && hit) begin
          used_we = 1'b1;
          used_wa = cur_r;
          nxt_we  = (prev_slot_r != NULL_SLOT);
          nxt_wa  = prev_slot_r;
          nxt_wd  = next_q;
        end
      end
      S_LINK1: begin
        se_we   = 1'b1;
        nxt_we  = 1'b1;
        used_we = 1'b1;
        used_wa = b_r;
        used_wd = 1'b1;
      end
      S_LINK2: begin
        nxt_we = (lo_r != NULL_SLOT);
        nxt_wa = lo_r;
        nxt_wd = b_r;
      end
      default: begin
        rd_addr = cur_r;
      end
    endcase
  end

  // Region table memories with registered read data.
  always_ff @(posedge clk) begin
    if (se_we) begin
      start_mem[b_r] <= addr_r;
      end_mem[b_r]   <= end_r;
    end
    if (nxt_we) begin
      next_mem[nxt_wa] <= nxt_wd;
    end
    start_q <= start_mem[rd_addr];
    end_q   <= end_mem[rd_addr];
    next_q  <= next_mem[rd_addr];
  end

  // Slot-use memory, read only by the free-slot scan.
  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_q <= used_mem[scan_r];
  end

  // Sequencer, table state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= NULL_SLOT;
      head_r      <= NULL_SLOT;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The result state reloads the output register itself whenever out_ready is high.
      if (out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        // Clear the slot-use memory after reset.
        S_CLEAR: begin
          clr_r <= clr_r + ONE_SLOT;
          if (clr_r == LAST_SLOT) begin
            state_r <= S_IDLE;
          end
        end
        // Take a new transaction.
        S_IDLE: begin
          if (in_valid) begin
            cmd_r      <= in_data.cmd;
            addr_r     <= in_data.address;
            len_r      <= in_data.length;
            end_r      <= {1'b0, in_data.address} + {1'b0, in_data.length};
            scan_r     <= ONE_SLOT;
            chk_vld_r  <= 1'b0;
            slot_res_r <= NULL_SLOT;
            rel_r      <= '0;
            if (in_data.cmd == CMD_REGISTER) begin
              state_r <= S_FREE;
            end else begin
              state_r <= S_HEAD;
            end
          end
        end
        // Scan for the lowest free slot, one read a cycle.
        S_FREE: begin
          chk_vld_r <= 1'b1;
          chk_r     <= scan_r;
          if (scan_r != LAST_SLOT) begin
            scan_r <= scan_r + ONE_SLOT;
          end
          if (chk_vld_r && !used_q) begin
            b_r     <= chk_r;
            state_r <= S_HEAD;
          end else if (chk_vld_r && chk_r == LAST_SLOT) begin
            stat_r  <= ST_FULL;
            state_r <= S_RESP;
          end
        end
        // Start of the list walk; an empty list is handled here.
        S_HEAD: begin
          if (head_r == NULL_SLOT) begin
            if (cmd_r == CMD_REGISTER) begin
              lo_r    <= NULL_SLOT;
              hi_r    <= NULL_SLOT;
              state_r <= S_LINK1;
            end else begin
              stat_r  <= ST_NOTFOUND;
              state_r <= S_RESP;
            end
          end else begin
            cur_r       <= head_r;
            prev_slot_r <= NULL_SLOT;
            state_r     <= S_WALK;
          end
        end
        // One list node a cycle.
        S_WALK: begin
          if (cmd_r == CMD_REGISTER) begin
            if (eq_start) begin
              stat_r  <= ST_OVERLAP;
              state_r <= S_RESP;
            end else if (below) begin
              if (prev_clash || succ_clash) begin
                stat_r  <= ST_OVERLAP;
                state_r <= S_RESP;
              end else begin
                lo_r    <= prev_slot_r;
                hi_r    <= cur_r;
                state_r <= S_LINK1;
              end
            end else if (at_tail) begin
              if (tail_clash) begin
                stat_r  <= ST_OVERLAP;
                state_r <= S_RESP;
              end else begin
                lo_r    <= cur_r;
                hi_r    <= NULL_SLOT;
                state_r <= S_LINK1;
              end
            end else begin
              prev_slot_r <= cur_r;
              prev_end_r  <= end_q;
              cur_r       <= next_q;
            end
          end else begin
            if (hit) begin
              // Unlink the node; the slot-use and link writes happen this cycle.
              if (prev_slot_r == NULL_SLOT) begin
                head_r <= next_q;
              end
              total_r    <= total_r - {1'b0, node_len};
              if (count_r != '0) begin
                count_r <= count_r - ONE_SLOT;
              end
              rel_r      <= node_len;
              slot_res_r <= cur_r;
              stat_r     <= ST_OK;
              state_r    <= S_RESP;
            end else if (at_tail) begin
              stat_r  <= ST_NOTFOUND;
              state_r <= S_RESP;
            end else begin
              prev_slot_r <= cur_r;
              prev_end_r  <= end_q;
              cur_r       <= next_q;
            end
          end
        end
        // Write the new node's entry and forward link.
        S_LINK1: begin
          state_r <= S_LINK2;
        end
        // Point the predecessor, or the head, at the new node.
        S_LINK2: begin
          if (lo_r == NULL_SLOT) begin
            head_r <= b_r;
          end
          count_r    <= count_r + ONE_SLOT;
          total_r    <= total_r + {1'b0, len_r};
          slot_res_r <= b_r;
          stat_r     <= ST_OK;
          state_r    <= S_RESP;
        end
        // Load the result once the output register is free.
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                <= 1'b1;
            out_data_r.status          <= stat_r;
            out_data_r.slot            <= 8'(slot_res_r);
            out_data_r.live_count      <= 8'(count_r);
            out_data_r.total_bytes     <= total_r;
            out_data_r.released_length <= rel_r;
            state_r                    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/art_checker.sv -----
// Port-level checks for the address region tracker, attached by the bind below.
// Depends on art_pkg for payload types and status codes.
module art_checker #(
  parameter int unsigned TABLE_SLOTS = art_pkg::ART_SLOTS_DEFAULT
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input art_pkg::art_out_t out_data
);
  import art_pkg::*;

  // A transaction is worked on alone, so the input closes after each acceptance.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again in the cycle after an acceptance");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // A failed command reports no slot and no released length.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK ||
                   (out_data.slot == 8'd0 && out_data.released_length == 32'd0)))
    else $error("failed command reports a slot or a released length");

  // The table is full only when every usable slot is taken.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.live_count == 8'(TABLE_SLOTS - 1))
    else $error("table full reported with free slots left");

  // A successful command always names a real slot.
  a_ok_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK && TABLE_SLOTS <= 256 |-> out_data.slot != 8'd0)
    else $error("successful command reports slot zero");

endmodule

bind address_region_tracker art_checker #(.TABLE_SLOTS(TABLE_SLOTS)) u_art_checker (.*);
